// ===== src/osm_pkg.sv =====
// Shared constants, codes and types of the order statistic multiset.
`default_nettype none
package osm_pkg;

  localparam int DISTINCT_DEPTH_DEF = 1024;
  localparam int TOTAL_CAPACITY_DEF = 1024;

  localparam int VALUE_W = 32;
  localparam int RANK_W  = 11;

  localparam logic signed [VALUE_W-1:0] SENT_LO = -32'sd1000000000;
  localparam logic signed [VALUE_W-1:0] SENT_HI = 32'sd1000000000;

  typedef enum logic [1:0] {
    MODE_INSERT = 2'd0,
    MODE_REMOVE = 2'd1,
    MODE_QUERY  = 2'd2
  } mode_t;

  typedef enum logic [2:0] {
    ST_OK      = 3'd0,
    ST_LOW     = 3'd1,
    ST_PAST    = 3'd2,
    ST_FULL    = 3'd3,
    ST_MISSING = 3'd4
  } status_t;

endpackage
`default_nettype wire

// ===== src/osm_table.sv =====
// Sorted entry table: one write port, one read port with registered read data.
`default_nettype none
module osm_table #(
  parameter int DEPTH = osm_pkg::DISTINCT_DEPTH_DEF,
  parameter int CNT_W = 11
) (
  input  wire logic                                clk,
  input  wire logic                                we,
  input  wire logic [$clog2(DEPTH)-1:0]            waddr,
  input  wire logic signed [osm_pkg::VALUE_W-1:0]  wval,
  input  wire logic [CNT_W-1:0]                    wcnt,
  input  wire logic [$clog2(DEPTH)-1:0]            raddr,
  output logic signed [osm_pkg::VALUE_W-1:0]       rval,
  output logic [CNT_W-1:0]                         rcnt
);
  import osm_pkg::*;

  logic signed [VALUE_W-1:0] val_mem [DEPTH];
  logic [CNT_W-1:0]          cnt_mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      val_mem[waddr] <= wval;
      cnt_mem[waddr] <= wcnt;
    end
    rval <= val_mem[raddr];
    rcnt <= cnt_mem[raddr];
  end

endmodule
`default_nettype wire

// ===== src/order_statistic_multiset_unit.sv =====
// Top level of the order statistic multiset: sequencer, counters and result register.
//
// A bounded multiset of signed 32-bit values kept as a table of distinct values
// in ascending order, each with a count of copies.
// Request channel: a request (in_mode, in_value, in_query_rank) is taken at a
// rising edge where start is high and busy is low. Mode insert adds one copy,
// remove takes one copy away, query returns the element of rank in_query_rank
// (rank 1 is the smallest, counting copies); the unused mode changes nothing.
// Result channel: out_valid is high for exactly one cycle with out_result_value
// and out_status; the receiver cannot hold a result off, none is ever dropped.
// busy falls in the same cycle in which the result appears.
// The unused mode, a query of rank zero and an insert into a multiset that holds
// its element capacity answer in the cycle after the request. Every other request
// walks the table through its single read port, one entry per cycle, and answers
// when the walk reaches its entry or passes the last one. An insert of a new value
// into a table with a free entry, or a remove of a last copy, stops the walk at its
// position and then moves the entries above it by one place, one entry per cycle
// through the same port.
// Reset empties the multiset at once; the table contents need no clearing.
`default_nettype none
module order_statistic_multiset_unit #(
  parameter int DISTINCT_DEPTH = osm_pkg::DISTINCT_DEPTH_DEF,
  parameter int TOTAL_CAPACITY = osm_pkg::TOTAL_CAPACITY_DEF
) (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                start,
  output logic                                     busy,
  input  wire logic [1:0]                          in_mode,
  input  wire logic signed [osm_pkg::VALUE_W-1:0]  in_value,
  input  wire logic [osm_pkg::RANK_W-1:0]          in_query_rank,
  output logic                                     out_valid,
  output logic signed [osm_pkg::VALUE_W-1:0]       out_result_value,
  output logic [2:0]                               out_status
);
  import osm_pkg::*;

  // Index into the table, a count of distinct entries, a count of elements.
  localparam int IDX_W = $clog2(DISTINCT_DEPTH);
  localparam int DCW   = $clog2(DISTINCT_DEPTH + 1);
  localparam int TCW   = $clog2(TOTAL_CAPACITY + 1);
  localparam int RW    = (TCW > RANK_W) ? TCW : RANK_W;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_SHUP,
    S_SHDN
  } state_t;

  state_t                    state_r, state_nxt;
  logic [1:0]                op_r, op_nxt;
  logic signed [VALUE_W-1:0] val_r, val_nxt;
  logic [RANK_W-1:0]         rank_r, rank_nxt;
  logic [DCW-1:0]            idx_r, idx_nxt;
  logic [IDX_W-1:0]          chk_r, chk_nxt;
  logic                      vld_r, vld_nxt;
  logic [TCW-1:0]            seen_r, seen_nxt;
  logic [IDX_W-1:0]          pos_r, pos_nxt;
  logic [IDX_W-1:0]          sh_r, sh_nxt;
  logic [IDX_W-1:0]          wa_r, wa_nxt;
  logic [DCW-1:0]            mv_r, mv_nxt;
  logic                      pend_r, pend_nxt;
  logic [DCW-1:0]            distinct_r, distinct_nxt;
  logic [TCW-1:0]            total_r, total_nxt;
  logic                      busy_r, busy_nxt;
  logic                      out_valid_r, out_valid_nxt;
  logic signed [VALUE_W-1:0] out_value_r, out_value_nxt;
  status_t                   out_status_r, out_status_nxt;

  // Table port signals.
  logic                      tb_we;
  logic [IDX_W-1:0]          tb_waddr;
  logic signed [VALUE_W-1:0] tb_wval;
  logic [TCW-1:0]            tb_wcnt;
  logic [IDX_W-1:0]          tb_raddr;
  logic signed [VALUE_W-1:0] tb_rval;
  logic [TCW-1:0]            tb_rcnt;

  // Helper values for the scan.
  logic [TCW-1:0] seen_sum;
  logic [DCW-1:0] ins_pos;
  logic [DCW-1:0] distinct_m1;

  osm_table #(
    .DEPTH (DISTINCT_DEPTH),
    .CNT_W (TCW)
  ) u_table (
    .clk   (clk),
    .we    (tb_we),
    .waddr (tb_waddr),
    .wval  (tb_wval),
    .wcnt  (tb_wcnt),
    .raddr (tb_raddr),
    .rval  (tb_rval),
    .rcnt  (tb_rcnt)
  );

  assign seen_sum    = seen_r + tb_rcnt;
  assign distinct_m1 = distinct_r - DCW'(1);
  // An insert goes in front of the first larger entry, or after the last one.
  assign ins_pos     = vld_r ? DCW'(chk_r) : distinct_r;
  // The scan reads through idx_r; the shifts read through sh_r.
  assign tb_raddr    = (state_r == S_SCAN) ? idx_r[IDX_W-1:0] : sh_r;

  always_comb begin
    state_nxt      = state_r;
    op_nxt         = op_r;
    val_nxt        = val_r;
    rank_nxt       = rank_r;
    idx_nxt        = idx_r;
    chk_nxt        = chk_r;
    vld_nxt        = vld_r;
    seen_nxt       = seen_r;
    pos_nxt        = pos_r;
    sh_nxt         = sh_r;
    wa_nxt         = wa_r;
    mv_nxt         = mv_r;
    pend_nxt       = pend_r;
    distinct_nxt   = distinct_r;
    total_nxt      = total_r;
    busy_nxt       = busy_r;
    out_valid_nxt  = 1'b0;
    out_value_nxt  = out_value_r;
    out_status_nxt = out_status_r;
    tb_we          = 1'b0;
    tb_waddr       = chk_r;
    tb_wval        = val_r;
    tb_wcnt        = tb_rcnt;

    case (state_r)
      S_IDLE: begin
        if (start) begin
          op_nxt        = in_mode;
          val_nxt       = in_value;
          rank_nxt      = in_query_rank;
          idx_nxt       = '0;
          vld_nxt       = 1'b0;
          seen_nxt      = '0;
          out_value_nxt = '0;
          case (in_mode)
            MODE_INSERT: begin
              if (total_r >= TCW'(TOTAL_CAPACITY)) begin
                out_valid_nxt  = 1'b1;
                out_status_nxt = ST_FULL;
              end else begin
                state_nxt = S_SCAN;
                busy_nxt  = 1'b1;
              end
            end
            MODE_REMOVE: begin
              state_nxt = S_SCAN;
              busy_nxt  = 1'b1;
            end
            MODE_QUERY: begin
              if (in_query_rank == '0) begin
                out_valid_nxt  = 1'b1;
                out_status_nxt = ST_LOW;
                out_value_nxt  = SENT_LO;
              end else begin
                state_nxt = S_SCAN;
                busy_nxt  = 1'b1;
              end
            end
            default: begin
              out_valid_nxt  = 1'b1;
              out_status_nxt = ST_OK;
            end
          endcase
        end
      end

      S_SCAN: begin
        // Read one entry per cycle; the data of the previous read is checked here.
        if (idx_r < distinct_r) begin
          idx_nxt = idx_r + DCW'(1);
          vld_nxt = 1'b1;
          chk_nxt = idx_r[IDX_W-1:0];
        end else begin
          vld_nxt = 1'b0;
        end

        if (vld_r || (idx_r >= distinct_r)) begin
          case (op_r)
            MODE_INSERT: begin
              if (vld_r && (tb_rval == val_r)) begin
                tb_we          = 1'b1;
                tb_waddr       = chk_r;
                tb_wval        = val_r;
                tb_wcnt        = tb_rcnt + TCW'(1);
                total_nxt      = total_r + TCW'(1);
                state_nxt      = S_IDLE;
                busy_nxt       = 1'b0;
                out_valid_nxt  = 1'b1;
                out_status_nxt = ST_OK;
              end else if (!vld_r || (tb_rval > val_r)) begin
                if (distinct_r >= DCW'(DISTINCT_DEPTH)) begin
                  state_nxt      = S_IDLE;
                  busy_nxt       = 1'b0;
                  out_valid_nxt  = 1'b1;
                  out_status_nxt = ST_FULL;
                end else begin
                  pos_nxt   = ins_pos[IDX_W-1:0];
                  mv_nxt    = distinct_r - ins_pos;
                  sh_nxt    = distinct_m1[IDX_W-1:0];
                  pend_nxt  = 1'b0;
                  state_nxt = S_SHUP;
                end
              end
            end
            MODE_REMOVE: begin
              if (vld_r && (tb_rval == val_r)) begin
                total_nxt = total_r - TCW'(1);
                if (tb_rcnt != TCW'(1)) begin
                  tb_we          = 1'b1;
                  tb_waddr       = chk_r;
                  tb_wval        = val_r;
                  tb_wcnt        = tb_rcnt - TCW'(1);
                  state_nxt      = S_IDLE;
                  busy_nxt       = 1'b0;
                  out_valid_nxt  = 1'b1;
                  out_status_nxt = ST_OK;
                end else begin
                  pos_nxt   = chk_r;
                  mv_nxt    = distinct_m1 - DCW'(chk_r);
                  sh_nxt    = chk_r + IDX_W'(1);
                  pend_nxt  = 1'b0;
                  state_nxt = S_SHDN;
                end
              end else if (!vld_r || (tb_rval > val_r)) begin
                state_nxt      = S_IDLE;
                busy_nxt       = 1'b0;
                out_valid_nxt  = 1'b1;
                out_status_nxt = ST_MISSING;
              end
            end
            MODE_QUERY: begin
              if (vld_r) begin
                seen_nxt = seen_sum;
                if (RW'(rank_r) <= RW'(seen_sum)) begin
                  state_nxt      = S_IDLE;
                  busy_nxt       = 1'b0;
                  out_valid_nxt  = 1'b1;
                  out_status_nxt = ST_OK;
                  out_value_nxt  = tb_rval;
                end
              end else begin
                state_nxt      = S_IDLE;
                busy_nxt       = 1'b0;
                out_valid_nxt  = 1'b1;
                out_status_nxt = ST_PAST;
                out_value_nxt  = SENT_HI;
              end
            end
            default: begin
              state_nxt      = S_IDLE;
              busy_nxt       = 1'b0;
              out_valid_nxt  = 1'b1;
              out_status_nxt = ST_OK;
            end
          endcase
        end
      end

      S_SHUP: begin
        // Move entries one place up, top first, then drop the new entry in.
        if (pend_r) begin
          tb_we    = 1'b1;
          tb_waddr = wa_r;
          tb_wval  = tb_rval;
          tb_wcnt  = tb_rcnt;
        end
        if (mv_r != '0) begin
          pend_nxt = 1'b1;
          wa_nxt   = sh_r + IDX_W'(1);
          sh_nxt   = sh_r - IDX_W'(1);
          mv_nxt   = mv_r - DCW'(1);
        end else begin
          pend_nxt = 1'b0;
          if (!pend_r) begin
            tb_we          = 1'b1;
            tb_waddr       = pos_r;
            tb_wval        = val_r;
            tb_wcnt        = TCW'(1);
            distinct_nxt   = distinct_r + DCW'(1);
            total_nxt      = total_r + TCW'(1);
            state_nxt      = S_IDLE;
            busy_nxt       = 1'b0;
            out_valid_nxt  = 1'b1;
            out_status_nxt = ST_OK;
          end
        end
      end

      S_SHDN: begin
        // Close the gap left by a removed entry, bottom first.
        if (pend_r) begin
          tb_we    = 1'b1;
          tb_waddr = wa_r;
          tb_wval  = tb_rval;
          tb_wcnt  = tb_rcnt;
        end
        if (mv_r != '0) begin
          pend_nxt = 1'b1;
          wa_nxt   = sh_r - IDX_W'(1);
          sh_nxt   = sh_r + IDX_W'(1);
          mv_nxt   = mv_r - DCW'(1);
        end else begin
          pend_nxt = 1'b0;
          if (!pend_r) begin
            distinct_nxt   = distinct_m1;
            state_nxt      = S_IDLE;
            busy_nxt       = 1'b0;
            out_valid_nxt  = 1'b1;
            out_status_nxt = ST_OK;
          end
        end
      end

      default: begin
        state_nxt = S_IDLE;
        busy_nxt  = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      vld_r        <= 1'b0;
      pend_r       <= 1'b0;
      distinct_r   <= '0;
      total_r      <= '0;
      busy_r       <= 1'b0;
      out_valid_r  <= 1'b0;
      out_value_r  <= '0;
      out_status_r <= ST_OK;
    end else begin
      state_r      <= state_nxt;
      vld_r        <= vld_nxt;
      pend_r       <= pend_nxt;
      distinct_r   <= distinct_nxt;
      total_r      <= total_nxt;
      busy_r       <= busy_nxt;
      out_valid_r  <= out_valid_nxt;
      out_value_r  <= out_value_nxt;
      out_status_r <= out_status_nxt;
    end
    op_r   <= op_nxt;
    val_r  <= val_nxt;
    rank_r <= rank_nxt;
    idx_r  <= idx_nxt;
    chk_r  <= chk_nxt;
    seen_r <= seen_nxt;
    pos_r  <= pos_nxt;
    sh_r   <= sh_nxt;
    wa_r   <= wa_nxt;
    mv_r   <= mv_nxt;
  end

  assign busy             = busy_r;
  assign out_valid        = out_valid_r;
  assign out_result_value = out_value_r;
  assign out_status       = out_status_r;

`ifndef ASSERT_OFF
  // A result only follows a request that was taken or one still in work.
  a_result_has_request: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ($past(busy_r) || $past(start)))
    else $error("result without a pending request");

  // A taken request either answers at once or keeps the block busy.
  a_request_progress: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> (busy || out_valid))
    else $error("request was lost");

  // Between requests every distinct entry holds at least one element. While a last
  // copy is being removed the element count already dropped and the entry count not yet.
  a_counts_consistent: assert property (@(posedge clk) disable iff (!rst_n)
    !busy_r |-> (RW'(distinct_r) <= RW'(total_r)))
    else $error("more distinct entries than elements");

  // The counters never pass their capacities.
  a_capacity: assert property (@(posedge clk) disable iff (!rst_n)
    (distinct_r <= DCW'(DISTINCT_DEPTH)) && (total_r <= TCW'(TOTAL_CAPACITY)))
    else $error("capacity exceeded");
`endif

endmodule
`default_nettype wire
